/* rtl/ptrs_pkg.sv */
// ptrs_pkg: field widths, register map and reset values for the pan/tilt
// raster scan sequencer.
// No dependencies; the core refers to it by scoped names.
`default_nettype none

package ptrs_pkg;

  localparam int unsigned PULSE_W = 12;
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 48;

  typedef logic [PULSE_W-1:0] pulse_t;
  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic [1:0]         reg_idx_t;

  // register index, taken from paddr[3:2]
  localparam reg_idx_t REG_MIN_PULSE = 2'd0;
  localparam reg_idx_t REG_MAX_PULSE = 2'd1;
  localparam reg_idx_t REG_STEP_DEG  = 2'd2;

  localparam pulse_t MIN_PULSE_RST = 12'd500;
  localparam pulse_t MAX_PULSE_RST = 12'd2400;
  localparam angle_t STEP_DEG_RST  = 8'd5;

endpackage

`default_nettype wire

/* rtl/pan_tilt_raster_scan_sequencer_core.sv */
// pan_tilt_raster_scan_sequencer_core: raster scan position sequencer with
// angle to servo pulse width mapping and an apb register port.
// Depends on ptrs_pkg.
//
//   channel | ports                      | content
//   --------+----------------------------+------------------------------------
//   in      | in_tvalid/tready/tdata     | one step tick request, beam state
//   out     | out_tvalid/tready/tdata    | pulse widths, angles, buzzer, active
//   cfg     | cfg_psel/penable/pwrite... | min/max pulse width, step angle
//
// One request per cycle sustained while the output is not stalled; each result
// passes the sequencing, angle times range multiply and reciprocal multiply stages.
// The scan position advances as the request is taken, so ticks chain freely.
// Synchronous active-low reset returns the scan to idle and the registers to
// their defaults. A stalled output holds its result and back-pressures the
// three stages in turn; empty stages keep taking requests.
`default_nettype none

module pan_tilt_raster_scan_sequencer_core #(
  parameter int unsigned MAX_ANGLE = 180
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // in_tdata: [0] beam_obstructed, [7:1] zero
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [ptrs_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: [11:0] pan_pulse_us, [23:12] tilt_pulse_us, [31:24] pan_deg,
  //            [39:32] tilt_deg, [40] buzzer_on, [41] active, [47:42] zero
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [ptrs_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire                                 cfg_psel,
  input  wire                                 cfg_penable,
  input  wire                                 cfg_pwrite,
  input  wire  [ptrs_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire  [ptrs_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ptrs_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int unsigned PW = ptrs_pkg::PULSE_W;
  localparam int unsigned AW = ptrs_pkg::ANGLE_W;
  localparam int unsigned PROD_W = PW + AW;
  // exact floor(n / MAX_ANGLE) for n < 2**PROD_W by multiply with ceil reciprocal
  localparam int unsigned LOG_D = $clog2(MAX_ANGLE);
  localparam int unsigned RECIP_SH = PROD_W + LOG_D;
  localparam int unsigned RECIP_W = PROD_W + 1;
  localparam logic [63:0] RECIP_M =
    ((64'd1 << RECIP_SH) + 64'(MAX_ANGLE) - 64'd1) / 64'(MAX_ANGLE);
  localparam int unsigned RMUL_W = PROD_W + RECIP_W;
  localparam logic [AW:0] MAX_SUM = (AW+1)'(MAX_ANGLE);
  localparam ptrs_pkg::angle_t MAX_DEG = AW'(MAX_ANGLE);

  // configuration
  ptrs_pkg::pulse_t min_pulse_r;
  ptrs_pkg::pulse_t max_pulse_r;
  ptrs_pkg::angle_t step_deg_r;

  // scan state
  logic             pan_desc_r;
  ptrs_pkg::angle_t pan_pos_r;
  ptrs_pkg::angle_t tilt_pos_r;
  logic             pan_desc_nxt;
  ptrs_pkg::angle_t pan_pos_nxt;
  ptrs_pkg::angle_t tilt_pos_nxt;

  // stage 1: commanded angles
  logic             s1_vld_r;
  ptrs_pkg::angle_t s1_pan_r;
  ptrs_pkg::angle_t s1_tilt_r;
  logic             s1_on_r;

  // stage 2: angle times pulse range
  logic              s2_vld_r;
  logic [PROD_W-1:0] s2_pan_prod_r;
  logic [PROD_W-1:0] s2_tilt_prod_r;
  ptrs_pkg::angle_t  s2_pan_r;
  ptrs_pkg::angle_t  s2_tilt_r;
  logic              s2_on_r;

  // stage 3: output register
  logic                              s3_vld_r;
  logic [ptrs_pkg::OUT_DATA_W-1:0]   s3_data_r;

  logic s1_rdy, s2_rdy, s3_rdy;
  logic in_acc;
  logic blocked;
  logic cfg_wr;

  ptrs_pkg::angle_t step_eff;
  logic [AW:0]      pan_sum;
  logic [AW:0]      tilt_sum;
  ptrs_pkg::pulse_t pulse_range;
  logic [PROD_W-1:0] pan_prod;
  logic [PROD_W-1:0] tilt_prod;
  logic [RMUL_W-1:0] pan_scaled;
  logic [RMUL_W-1:0] tilt_scaled;
  ptrs_pkg::pulse_t  pan_pulse;
  ptrs_pkg::pulse_t  tilt_pulse;

  assign s3_rdy = !s3_vld_r || out_tready;
  assign s2_rdy = !s2_vld_r || s3_rdy;
  assign s1_rdy = !s1_vld_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign in_acc = in_tvalid && in_tready;
  assign blocked = in_tdata[0];

  // next raster position
  always_comb begin
    step_eff = (step_deg_r == '0) ? AW'(1) : step_deg_r;
    pan_sum = {1'b0, pan_pos_r} + {1'b0, step_eff};
    tilt_sum = {1'b0, tilt_pos_r} + {1'b0, step_eff};
    pan_desc_nxt = pan_desc_r;
    pan_pos_nxt = pan_pos_r;
    tilt_pos_nxt = tilt_pos_r;
    if (!blocked) begin
      pan_desc_nxt = 1'b0;
      pan_pos_nxt = '0;
      tilt_pos_nxt = '0;
    end else if (!pan_desc_r) begin
      if (pan_sum <= MAX_SUM) begin
        pan_pos_nxt = pan_sum[AW-1:0];
      end else begin
        pan_desc_nxt = 1'b1;
        pan_pos_nxt = MAX_DEG;
      end
    end else if (pan_pos_r >= step_eff) begin
      pan_pos_nxt = pan_pos_r - step_eff;
    end else begin
      // bottom of the down sweep: next tilt row, wraps after the last row
      pan_desc_nxt = 1'b0;
      pan_pos_nxt = '0;
      tilt_pos_nxt = (tilt_sum <= MAX_SUM) ? tilt_sum[AW-1:0] : '0;
    end
  end

  // inverted range gives a zero span, so every pulse is min_pulse_us
  assign pulse_range = (max_pulse_r >= min_pulse_r) ? (max_pulse_r - min_pulse_r) : '0;
  assign pan_prod = PROD_W'(s1_pan_r) * PROD_W'(pulse_range);
  assign tilt_prod = PROD_W'(s1_tilt_r) * PROD_W'(pulse_range);

  assign pan_scaled = RMUL_W'(s2_pan_prod_r) * RMUL_W'(RECIP_M[RECIP_W-1:0]);
  assign tilt_scaled = RMUL_W'(s2_tilt_prod_r) * RMUL_W'(RECIP_M[RECIP_W-1:0]);
  assign pan_pulse = pan_scaled[RECIP_SH +: PW] + min_pulse_r;
  assign tilt_pulse = tilt_scaled[RECIP_SH +: PW] + min_pulse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_desc_r <= 1'b0;
      pan_pos_r <= '0;
      tilt_pos_r <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        pan_desc_r <= pan_desc_nxt;
        pan_pos_r <= pan_pos_nxt;
        tilt_pos_r <= tilt_pos_nxt;
      end
      if (s1_rdy) begin
        s1_vld_r <= in_acc;
      end
      if (s2_rdy) begin
        s2_vld_r <= s1_vld_r;
      end
      if (s3_rdy) begin
        s3_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pan_r <= blocked ? pan_pos_r : '0;
      s1_tilt_r <= blocked ? tilt_pos_r : '0;
      s1_on_r <= blocked;
    end
    if (s2_rdy && s1_vld_r) begin
      s2_pan_prod_r <= pan_prod;
      s2_tilt_prod_r <= tilt_prod;
      s2_pan_r <= s1_pan_r;
      s2_tilt_r <= s1_tilt_r;
      s2_on_r <= s1_on_r;
    end
    if (s3_rdy && s2_vld_r) begin
      s3_data_r <= {6'b0, s2_on_r, s2_on_r, s2_tilt_r, s2_pan_r, tilt_pulse, pan_pulse};
    end
  end

  assign out_tvalid = s3_vld_r;
  assign out_tdata = s3_data_r;

  // apb register port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r <= ptrs_pkg::MIN_PULSE_RST;
      max_pulse_r <= ptrs_pkg::MAX_PULSE_RST;
      step_deg_r <= ptrs_pkg::STEP_DEG_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        ptrs_pkg::REG_MIN_PULSE: min_pulse_r <= cfg_pwdata[PW-1:0];
        ptrs_pkg::REG_MAX_PULSE: max_pulse_r <= cfg_pwdata[PW-1:0];
        ptrs_pkg::REG_STEP_DEG:  step_deg_r <= cfg_pwdata[AW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      ptrs_pkg::REG_MIN_PULSE: cfg_prdata = ptrs_pkg::CFG_DATA_W'(min_pulse_r);
      ptrs_pkg::REG_MAX_PULSE: cfg_prdata = ptrs_pkg::CFG_DATA_W'(max_pulse_r);
      ptrs_pkg::REG_STEP_DEG:  cfg_prdata = ptrs_pkg::CFG_DATA_W'(step_deg_r);
      default:                 cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire
